[rtl/ip_address_text_parser_core_defines.svh]
// Assertion macros shared by the address text parser RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef IP_ADDRESS_TEXT_PARSER_CORE_DEFINES_SVH
`define IP_ADDRESS_TEXT_PARSER_CORE_DEFINES_SVH

// Condition holds at every edge outside reset.
`define IATP_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define IATP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IATP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/iatp_pkg.sv]
// Shared types and constants of the address text parser.
// No dependencies; imported by the front, back and top level modules.
package iatp_pkg;

    // Classified character, as handed from the front to the back.
    typedef struct packed {
        logic       is_term;
        logic       is_dot;
        logic       is_colon;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] val;
    } t_tok;

    // Head of the token queue as seen by the back part.
    typedef struct packed {
        logic valid;
        t_tok tok;
    } t_tokq;

    typedef struct packed {
        logic        status;
        logic        version;
        logic [63:0] address_high;
        logic [63:0] address_low;
    } t_result;

    localparam logic [3:0] V6_GROUPS    = 4'd8;
    localparam logic [2:0] V6_HEX_MAX   = 3'd4;
    localparam logic [1:0] V4_DIGIT_MAX = 2'd3;
    localparam logic [2:0] V4_OCT_LAST  = 3'd3;
    localparam logic [9:0] V4_OCT_MAX   = 10'd255;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;
    localparam logic VER_IPV4    = 1'b0;
    localparam logic VER_IPV6    = 1'b1;

endpackage

[rtl/iatp_front.sv]
// Front part: classifies each accepted character and queues the token.
// Depends on iatp_pkg and the assertion macro header.
`include "ip_address_text_parser_core_defines.svh"

module iatp_front #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_character,
    output logic          o_full,
    output iatp_pkg::t_tokq o_tokq,
    input  logic          i_tok_pop
);
    import iatp_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    t_tok            r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    t_tok            w_tok;
    logic            w_wr_en, w_rd_en;

    always_comb begin
        w_tok          = '0;
        w_tok.is_term  = (i_character == CHAR_NUL);
        w_tok.is_dot   = (i_character == CHAR_DOT);
        w_tok.is_colon = (i_character == CHAR_COLON);
        if (i_character >= CHAR_0 && i_character <= CHAR_9) begin
            w_tok.is_dec = 1'b1;
            w_tok.is_hex = 1'b1;
            w_tok.val    = 4'(i_character - CHAR_0);
        end else if (i_character >= CHAR_LA && i_character <= CHAR_LF) begin
            w_tok.is_hex = 1'b1;
            w_tok.val    = 4'(i_character - CHAR_LA + HEX_TEN);
        end else if (i_character >= CHAR_UA && i_character <= CHAR_UF) begin
            w_tok.is_hex = 1'b1;
            w_tok.val    = 4'(i_character - CHAR_UA + HEX_TEN);
        end
    end

    assign o_full       = (r_cnt == CNT_FULL);
    assign o_tokq.valid = (r_cnt != '0);
    assign o_tokq.tok   = r_mem[r_rd];
    assign w_wr_en      = i_push && !o_full;
    assign w_rd_en      = i_tok_pop && o_tokq.valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wr_en) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (w_rd_en) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (w_wr_en && !w_rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_wr_en && w_rd_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= w_tok;
        end
    end

    `IATP_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_FULL, "token count overflow")
    `IATP_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, w_rd_en, r_cnt != '0, "pop of empty queue")
    `IATP_ASSERT_NXT(a_push_grows, i_clk, i_rst_n, w_wr_en && !w_rd_en, r_cnt == $past(r_cnt) + 1'b1, "push lost")

endmodule

[rtl/iatp_back.sv]
// Back part: runs the IPv4 and IPv6 parse on queued tokens and queues results.
// Depends on iatp_pkg and the assertion macro header.
`include "ip_address_text_parser_core_defines.svh"

module iatp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  iatp_pkg::t_tokq i_tokq,
    output logic            o_tok_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_status,
    output logic            o_version,
    output logic [63:0]     o_address_high,
    output logic [63:0]     o_address_low
);
    import iatp_pkg::*;

    // parse state
    logic        r_seen_colon, n_seen_colon;
    logic [1:0]  r_v4_dc, n_v4_dc;
    logic [9:0]  r_v4_val, n_v4_val;
    logic [2:0]  r_v4_cnt, n_v4_cnt;
    logic        r_v4_failed, n_v4_failed;
    logic [7:0]  r_v4_oct [3];
    logic [127:0] r_groups;
    logic [3:0]  r_gi, n_gi;
    logic [2:0]  r_hc, n_hc;
    logic [15:0] r_hv, n_hv;
    logic        r_dfound, n_dfound;
    logic [3:0]  r_dpos, n_dpos;
    logic        r_pend, n_pend;
    logic        r_stopped, n_stopped;
    logic        r_v6_failed, n_v6_failed;

    // result queue
    t_result     r_rq [2];
    logic        r_rq_wr, r_rq_rd;
    logic [1:0]  r_rq_cnt, n_rq_cnt;
    logic        w_rq_full, w_rq_push, w_rq_pop;

    logic        w_take, w_term, w_fl_ok, w_grp_we, w_oct_we, c_skip, c_stop;
    logic [3:0]  w_fl_gi, c_gi;
    logic [2:0]  c_hc;
    logic [15:0] c_hv;
    t_tok        w_tok;

    // terminator path
    logic        w_fin, w_fin_fl, w_exp, w_v4_ok;
    logic [3:0]  w_gi_f, w_shift, w_pos;
    logic [4:0]  w_tail_start;
    logic [127:0] w_flat_f, w_shifted, w_v6_addr;
    t_result     w_res;

    assign w_tok     = i_tokq.tok;
    assign w_rq_full = (r_rq_cnt == 2'd2);
    assign w_take    = i_tokq.valid && (!w_tok.is_term || !w_rq_full);
    assign w_term    = w_take && w_tok.is_term;
    assign o_tok_pop = w_take;
    assign w_fl_ok   = (r_hc != '0) && (r_gi < V6_GROUPS);
    assign w_fl_gi   = r_gi + 1'b1;

    // Per-character update of both parses.
    always_comb begin
        n_seen_colon = r_seen_colon;
        n_v4_dc      = r_v4_dc;
        n_v4_val     = r_v4_val;
        n_v4_cnt     = r_v4_cnt;
        n_v4_failed  = r_v4_failed;
        n_dfound     = r_dfound;
        n_dpos       = r_dpos;
        n_pend       = r_pend;
        n_v6_failed  = r_v6_failed;
        w_grp_we     = 1'b0;
        w_oct_we     = 1'b0;
        c_gi         = r_gi;
        c_hc         = r_hc;
        c_hv         = r_hv;
        c_stop       = r_stopped;
        c_skip       = 1'b0;
        if (w_take && !w_tok.is_term) begin
            if (w_tok.is_colon) begin
                n_seen_colon = 1'b1;
            end
            if (!r_v4_failed) begin
                if (w_tok.is_dot) begin
                    if (r_v4_dc == '0 || r_v4_val > V4_OCT_MAX || r_v4_cnt > V4_OCT_LAST) begin
                        n_v4_failed = 1'b1;
                    end else begin
                        w_oct_we = (r_v4_cnt < V4_OCT_LAST);
                        n_v4_cnt = r_v4_cnt + 1'b1;
                        n_v4_dc  = '0;
                        n_v4_val = '0;
                    end
                end else if (w_tok.is_dec) begin
                    if (r_v4_dc == V4_DIGIT_MAX) begin
                        n_v4_failed = 1'b1;
                    end else begin
                        n_v4_val = 10'({r_v4_val[6:0], 3'b000}) + 10'({r_v4_val[8:0], 1'b0})
                                 + 10'(w_tok.val);
                        n_v4_dc  = r_v4_dc + 1'b1;
                    end
                end else begin
                    n_v4_failed = 1'b1;
                end
            end
            if (!r_stopped && !r_v6_failed) begin
                // resolve a held colon first
                if (r_pend) begin
                    n_pend = 1'b0;
                    if (w_fl_ok) begin
                        w_grp_we = 1'b1;
                        c_gi     = w_fl_gi;
                        c_hc     = '0;
                        c_hv     = '0;
                        c_stop   = (w_fl_gi == V6_GROUPS);
                    end
                    if (w_tok.is_colon && !r_dfound) begin
                        n_dfound = 1'b1;
                        n_dpos   = c_gi;
                        c_skip   = 1'b1;
                    end else if (c_stop) begin
                        c_skip = 1'b1;
                    end
                end
                if (!c_skip) begin
                    if (w_tok.is_colon) begin
                        n_pend = 1'b1;
                    end else if (w_tok.is_hex) begin
                        if (c_hc < V6_HEX_MAX) begin
                            c_hv = {c_hv[11:0], w_tok.val};
                            c_hc = c_hc + 1'b1;
                        end
                    end else begin
                        n_v6_failed = 1'b1;
                    end
                end
            end
        end
        n_gi      = c_gi;
        n_hc      = c_hc;
        n_hv      = c_hv;
        n_stopped = c_stop;
    end

    // Terminator: final flush, gap expansion and result assembly.
    always_comb begin
        w_fin    = !r_stopped && !r_v6_failed;
        w_fin_fl = w_fin && w_fl_ok;
        w_gi_f   = w_fin_fl ? w_fl_gi : r_gi;
        w_flat_f = r_groups;
        for (int k = 0; k < 8; k++) begin
            if (w_fin_fl && r_gi[2:0] == 3'(k)) begin
                w_flat_f[127 - 16*k -: 16] = r_hv;
            end
        end
        w_exp        = w_fin && r_dfound && (w_gi_f < V6_GROUPS);
        w_shift      = V6_GROUPS - w_gi_f;
        w_pos        = (r_dpos > w_gi_f) ? w_gi_f : r_dpos;
        w_tail_start = 5'(w_pos) + 5'(w_shift);
        w_shifted    = w_flat_f >> {w_shift, 4'b0000};
        w_v6_addr    = '0;
        for (int k = 0; k < 8; k++) begin
            if (w_exp) begin
                if (4'(k) < w_pos) begin
                    w_v6_addr[127 - 16*k -: 16] = w_flat_f[127 - 16*k -: 16];
                end else if (5'(k) >= w_tail_start) begin
                    w_v6_addr[127 - 16*k -: 16] = w_shifted[127 - 16*k -: 16];
                end
            end else if (4'(k) < w_gi_f) begin
                w_v6_addr[127 - 16*k -: 16] = w_flat_f[127 - 16*k -: 16];
            end
        end

        w_v4_ok = !r_v4_failed && (r_v4_dc != '0) && (r_v4_val <= V4_OCT_MAX)
                && (r_v4_cnt == V4_OCT_LAST);

        w_res = '0;
        if (r_seen_colon) begin
            w_res.version = VER_IPV6;
            w_res.status  = r_v6_failed ? STATUS_FAIL : STATUS_OK;
            if (!r_v6_failed) begin
                w_res.address_high = w_v6_addr[127:64];
                w_res.address_low  = w_v6_addr[63:0];
            end
        end else begin
            w_res.version = VER_IPV4;
            w_res.status  = w_v4_ok ? STATUS_OK : STATUS_FAIL;
            if (w_v4_ok) begin
                w_res.address_low = {32'd0, r_v4_val[7:0], r_v4_oct[2], r_v4_oct[1], r_v4_oct[0]};
            end
        end
    end

    assign w_rq_push = w_term;
    assign w_rq_pop  = i_pop && !o_empty;
    assign o_empty   = (r_rq_cnt == '0);

    always_comb begin
        n_rq_cnt = r_rq_cnt;
        if (w_rq_push && !w_rq_pop) begin
            n_rq_cnt = r_rq_cnt + 1'b1;
        end else if (!w_rq_push && w_rq_pop) begin
            n_rq_cnt = r_rq_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_term) begin
            r_seen_colon <= 1'b0;
            r_v4_dc      <= '0;
            r_v4_val     <= '0;
            r_v4_cnt     <= '0;
            r_v4_failed  <= 1'b0;
            r_gi         <= '0;
            r_hc         <= '0;
            r_hv         <= '0;
            r_dfound     <= 1'b0;
            r_dpos       <= '0;
            r_pend       <= 1'b0;
            r_stopped    <= 1'b0;
            r_v6_failed  <= 1'b0;
        end else begin
            r_seen_colon <= n_seen_colon;
            r_v4_dc      <= n_v4_dc;
            r_v4_val     <= n_v4_val;
            r_v4_cnt     <= n_v4_cnt;
            r_v4_failed  <= n_v4_failed;
            r_gi         <= n_gi;
            r_hc         <= n_hc;
            r_hv         <= n_hv;
            r_dfound     <= n_dfound;
            r_dpos       <= n_dpos;
            r_pend       <= n_pend;
            r_stopped    <= n_stopped;
            r_v6_failed  <= n_v6_failed;
        end
        if (!i_rst_n) begin
            r_rq_wr  <= 1'b0;
            r_rq_rd  <= 1'b0;
            r_rq_cnt <= '0;
        end else begin
            r_rq_cnt <= n_rq_cnt;
            if (w_rq_push) begin
                r_rq_wr <= !r_rq_wr;
            end
            if (w_rq_pop) begin
                r_rq_rd <= !r_rq_rd;
            end
        end
    end

    // payload storage, never read before written
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            if (w_grp_we && r_gi[2:0] == 3'(k)) begin
                r_groups[127 - 16*k -: 16] <= r_hv;
            end
        end
        if (w_oct_we) begin
            r_v4_oct[r_v4_cnt[1:0]] <= r_v4_val[7:0];
        end
        if (w_rq_push) begin
            r_rq[r_rq_wr] <= w_res;
        end
    end

    assign o_status       = r_rq[r_rq_rd].status;
    assign o_version      = r_rq[r_rq_rd].version;
    assign o_address_high = r_rq[r_rq_rd].address_high;
    assign o_address_low  = r_rq[r_rq_rd].address_low;

    `IATP_ASSERT_ALWAYS(a_rq_bound, i_clk, i_rst_n, r_rq_cnt <= 2'd2, "result queue overflow")
    `IATP_ASSERT_ALWAYS(a_gi_bound, i_clk, i_rst_n, r_gi <= V6_GROUPS, "group index past end")
    `IATP_ASSERT_IMP(a_stop_full, i_clk, i_rst_n, r_stopped, r_gi == V6_GROUPS, "stopped before eight groups")
    `IATP_ASSERT_NXT(a_term_result, i_clk, i_rst_n, o_tok_pop && i_tokq.tok.is_term, !o_empty, "terminator gave no result")

endmodule

[rtl/ip_address_text_parser_core.sv]
// IPv4 / IPv6 address text parser, top level.
// Instantiates iatp_front and iatp_back; depends on iatp_pkg.
//
// The block takes one text character per push and returns one result per string, when the
// 0 terminator arrives. Dotted-decimal IPv4 and hex IPv6 are parsed side by side; a colon
// anywhere in the string selects the IPv6 outcome. Throughput is one character per clock,
// sustained, with pop held high: the front classifies the character and writes it into a
// TOKQ_DEPTH-entry token queue, and the back applies one token per cycle to the parse state.
// From the push of the terminator, the result is registered first in the token queue and
// then in the back's two-entry result queue before it reaches the output ports. The back
// applies the final group flush and the double colon gap expansion combinationally, in the
// same cycle as it takes the terminator. If results are not popped, the result queue fills
// after two strings, the back holds at the next terminator, and full rises once the token
// queue has filled behind it.
module ip_address_text_parser_core #(
    parameter int unsigned TOKQ_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_character,
    output logic        empty,
    input  logic        pop,
    output logic        o_status,
    output logic        o_version,
    output logic [63:0] o_address_high,
    output logic [63:0] o_address_low
);
    import iatp_pkg::*;

    t_tokq w_tokq;
    logic  w_tok_pop;

    // Classify characters and buffer them as tokens.
    iatp_front #(
        .DEPTH (TOKQ_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_character (i_character),
        .o_full      (full),
        .o_tokq      (w_tokq),
        .i_tok_pop   (w_tok_pop)
    );

    // Advance the parse one token a cycle; hold a terminator while results back up.
    iatp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tokq         (w_tokq),
        .o_tok_pop      (w_tok_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_status       (o_status),
        .o_version      (o_version),
        .o_address_high (o_address_high),
        .o_address_low  (o_address_low)
    );

endmodule
